// ===== src/mwbm_pkg.sv =====
// shared constants, operation codes and control structs for the matching block
package mwbm_pkg;

  localparam int DEF_MAX_ROWS    = 16;
  localparam int DEF_MAX_COLS    = 16;
  localparam int DEF_WEIGHT_BITS = 16;

  localparam int ROW_BITS    = 4;
  localparam int COL_BITS    = 4;
  localparam int WT_BITS     = 16;
  localparam int CFG_BITS    = 5;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLS = 1'd1;

  localparam int OP_BITS = 4;
  localparam logic [OP_BITS-1:0] OP_IDLE   = 4'd0;
  localparam logic [OP_BITS-1:0] OP_WRD    = 4'd1;
  localparam logic [OP_BITS-1:0] OP_WEV    = 4'd2;
  localparam logic [OP_BITS-1:0] OP_INIT   = 4'd3;
  localparam logic [OP_BITS-1:0] OP_PHASE  = 4'd4;
  localparam logic [OP_BITS-1:0] OP_PUSHL  = 4'd5;
  localparam logic [OP_BITS-1:0] OP_POP    = 4'd6;
  localparam logic [OP_BITS-1:0] OP_POPD   = 4'd7;
  localparam logic [OP_BITS-1:0] OP_ROW_RD = 4'd8;
  localparam logic [OP_BITS-1:0] OP_ROW_EV = 4'd9;
  localparam logic [OP_BITS-1:0] OP_FLIP   = 4'd10;
  localparam logic [OP_BITS-1:0] OP_D1     = 4'd11;
  localparam logic [OP_BITS-1:0] OP_D2     = 4'd12;
  localparam logic [OP_BITS-1:0] OP_UPD    = 4'd13;
  localparam logic [OP_BITS-1:0] OP_SLK    = 4'd14;
  localparam logic [OP_BITS-1:0] OP_OUT    = 4'd15;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
  } mwbm_cmd_t;

  typedef struct packed {
    logic start;
    logic m_zero;
    logic n_zero;
    logic row_end;
    logic col_end;
    logic col_first;
    logic stk_empty;
    logic pop_left;
    logic pop_free_right;
    logic flip_end;
    logic d1_hit;
    logic stop;
    logic out_load;
  } mwbm_stat_t;

endpackage

// ===== src/mwbm_in_if.sv =====
// weight entry channel
interface mwbm_in_if import mwbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ROW_BITS-1:0] row;
  logic [COL_BITS-1:0] col;
  logic [WT_BITS-1:0]  weight;
  logic                last;
  modport source (output valid, row, col, weight, last, input ready);
  modport sink (input valid, row, col, weight, last, output ready);
endinterface

// ===== src/mwbm_out_if.sv =====
// matching result channel
interface mwbm_out_if import mwbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ROW_BITS-1:0] row_res;
  logic [COL_BITS-1:0] col_res;
  logic                matched;
  logic                last_pair;
  modport source (output valid, row_res, col_res, matched, last_pair, input ready);
  modport sink (input valid, row_res, col_res, matched, last_pair, output ready);
endinterface

// ===== src/mwbm_cfg_if.sv =====
// register write channel
interface mwbm_cfg_if import mwbm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [CFG_BITS-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/mwbm_ctrl.sv =====
// sequencer for load, weight scan, search phases and result output
module mwbm_ctrl import mwbm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  mwbm_stat_t stat,
  output mwbm_cmd_t  cmd
);

  logic [OP_BITS-1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      OP_IDLE: begin
        if (stat.start) begin
          if (stat.m_zero) state_nxt = OP_IDLE;
          else if (stat.n_zero) state_nxt = OP_INIT;
          else state_nxt = OP_WRD;
        end
      end
      OP_WRD:    state_nxt = OP_WEV;
      OP_WEV:    if (stat.row_end && stat.col_end) state_nxt = OP_INIT;
                 else state_nxt = OP_WRD;
      OP_INIT:   state_nxt = stat.n_zero ? OP_OUT : OP_PHASE;
      OP_PHASE:  state_nxt = OP_PUSHL;
      OP_PUSHL:  if (stat.row_end) state_nxt = OP_POP;
      OP_POP:    state_nxt = stat.stk_empty ? OP_D1 : OP_POPD;
      OP_POPD: begin
        if (stat.pop_left) state_nxt = OP_ROW_RD;
        else if (stat.pop_free_right) state_nxt = OP_FLIP;
        else state_nxt = OP_POP;
      end
      OP_ROW_RD: state_nxt = OP_ROW_EV;
      OP_ROW_EV: state_nxt = stat.col_first ? OP_POP : OP_ROW_RD;
      OP_FLIP:   if (stat.flip_end) state_nxt = OP_PHASE;
      OP_D1:     if (stat.d1_hit || stat.row_end) state_nxt = OP_D2;
      OP_D2:     if (stat.col_end) state_nxt = OP_UPD;
      OP_UPD:    state_nxt = stat.stop ? OP_OUT : OP_SLK;
      OP_SLK:    if (stat.col_end) state_nxt = OP_POP;
      OP_OUT:    if (stat.out_load && stat.row_end) state_nxt = OP_IDLE;
      default:   state_nxt = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= OP_IDLE;
    else state_r <= state_nxt;
  end

  assign cmd.op = state_r;

endmodule

// ===== src/mwbm_dp.sv =====
// weight memory, potentials, slacks, mates, search stack and output register
module mwbm_dp import mwbm_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mwbm_cmd_t   cmd,
  output mwbm_stat_t  stat,
  mwbm_in_if.sink     in_ch,
  mwbm_out_if.source  out_ch,
  mwbm_cfg_if.sink    cfg_ch
);

  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int IW    = (RIW > CIW) ? RIW : CIW;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SD    = MAX_ROWS + MAX_COLS;
  localparam int SIW   = $clog2(SD);
  localparam int SPW   = $clog2(SD + 1);
  localparam int PW    = WEIGHT_BITS + 1;
  localparam int SW    = WEIGHT_BITS + 2;
  localparam logic [SW-1:0] SLACK_INF = {SW{1'b1}};

  // weight store and search stack
  logic [WEIGHT_BITS-1:0] wmem [DEPTH];
  logic [WEIGHT_BITS-1:0] rdata_r;
  logic [IW:0]            stk_mem [SD];
  logic [IW:0]            stk_q_r;

  logic [CFG_BITS-1:0]    rows_cfg_r, cols_cfg_r;
  logic [RCW-1:0]         m_r, m_in;
  logic [CCW-1:0]         n_r, n_in;
  logic [WEIGHT_BITS-1:0] maxw_r, w_r;
  logic [RIW-1:0]         ri_r, a_r;
  logic [CIW-1:0]         cj_r, b_r;
  logic [SPW-1:0]         sp_r;
  logic [SW-1:0]          d1_r, d2_r;

  logic                   lm_v_r  [MAX_ROWS];
  logic [CIW-1:0]         lm_c_r  [MAX_ROWS];
  logic                   rm_v_r  [MAX_COLS];
  logic [RIW-1:0]         rm_a_r  [MAX_COLS];
  logic [PW-1:0]          lp_r    [MAX_ROWS];
  logic [PW-1:0]          rp_r    [MAX_COLS];
  logic                   lreach_r [MAX_ROWS];
  logic                   rreach_r [MAX_COLS];
  logic [SW-1:0]          slack_r [MAX_COLS];
  logic [RIW-1:0]         par_r   [MAX_COLS];

  logic                   out_valid_r, matched_r, last_pair_r;
  logic [ROW_BITS-1:0]    row_res_r;
  logic [COL_BITS-1:0]    col_res_r;

  logic [31:0]            wext;
  logic [WEIGHT_BITS-1:0] wt, wmax_in;
  logic                   in_acc, in_ok;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic                   pop_side;
  logic [IW-1:0]          pop_idx;
  logic [CIW-1:0]         pb;
  logic [RIW-1:0]         popd_a, flip_a;
  logic [SW-1:0]          z_row, s_new;
  logic                   upd_row, slk_upd;
  logic                   push_en, push_ok;
  logic [IW:0]            push_code;
  logic                   row_end, col_end, stop, out_load;

  assign in_ch.ready  = (cmd.op == OP_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc = in_ch.valid && in_ch.ready;

  assign wext    = 32'(in_ch.weight);
  assign wt      = wext[WEIGHT_BITS-1:0];
  assign wmax_in = (wt > maxw_r) ? wt : maxw_r;
  assign in_ok   = (32'(in_ch.row) < MAX_ROWS) && (32'(in_ch.col) < MAX_COLS);
  assign wr_addr = AW'(in_ch.row) * AW'(MAX_COLS) + AW'(in_ch.col);
  assign rd_addr = (cmd.op == OP_ROW_RD) ? AW'(a_r) * AW'(MAX_COLS) + AW'(cj_r)
                                         : AW'(ri_r) * AW'(MAX_COLS) + AW'(cj_r);

  assign m_in = (32'(rows_cfg_r) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_cfg_r);
  assign n_in = (32'(cols_cfg_r) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_cfg_r);

  assign pop_side = stk_q_r[IW];
  assign pop_idx  = stk_q_r[IW-1:0];
  assign pb       = CIW'(pop_idx);
  assign popd_a   = rm_a_r[pb];
  assign flip_a   = par_r[b_r];

  assign z_row   = SW'(lp_r[a_r]) + SW'(rp_r[cj_r]) - SW'(rdata_r);
  assign upd_row = !rreach_r[cj_r] && (z_row < slack_r[cj_r]);
  assign s_new   = slack_r[cj_r] - d2_r;
  assign slk_upd = !rreach_r[cj_r] && (slack_r[cj_r] != SLACK_INF);

  assign row_end  = (RCW'(ri_r) + RCW'(1)) == m_r;
  assign col_end  = (CCW'(cj_r) + CCW'(1)) == n_r;
  assign stop     = (d1_r <= d2_r);
  assign out_load = !out_valid_r || out_ch.ready;

  always_comb begin
    push_en   = 1'b0;
    push_code = {1'b0, IW'(ri_r)};
    case (cmd.op)
      OP_PUSHL: push_en = !lm_v_r[ri_r];
      OP_POPD: begin
        push_en   = pop_side && rm_v_r[pb] && !lreach_r[popd_a];
        push_code = {1'b0, IW'(popd_a)};
      end
      OP_ROW_EV: begin
        push_en   = upd_row && (z_row == '0);
        push_code = {1'b1, IW'(cj_r)};
      end
      OP_SLK: begin
        push_en   = slk_upd && (s_new == '0);
        push_code = {1'b1, IW'(cj_r)};
      end
      default: push_en = 1'b0;
    endcase
  end
  assign push_ok = push_en && (32'(sp_r) < SD);

  always_comb begin
    stat.start          = in_acc && in_ch.last;
    stat.m_zero         = (m_in == '0);
    stat.n_zero         = (cmd.op == OP_IDLE) ? (n_in == '0) : (n_r == '0);
    stat.row_end        = row_end;
    stat.col_end        = col_end;
    stat.col_first      = (cj_r == '0);
    stat.stk_empty      = (sp_r == '0);
    stat.pop_left       = !pop_side;
    stat.pop_free_right = pop_side && !rm_v_r[pb];
    stat.flip_end       = !lm_v_r[flip_a];
    stat.d1_hit         = !lm_v_r[ri_r];
    stat.stop           = stop;
    stat.out_load       = out_load;
  end

  // memories
  always_ff @(posedge clk) begin
    if (in_acc && in_ok) wmem[wr_addr] <= wt;
    rdata_r <= wmem[rd_addr];
    if (push_ok) stk_mem[SIW'(sp_r)] <= push_code;
    stk_q_r <= stk_mem[SIW'(sp_r - SPW'(1))];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r  <= CFG_BITS'(16);
      cols_cfg_r  <= CFG_BITS'(16);
      maxw_r      <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == CFG_ROWS) rows_cfg_r <= cfg_ch.data;
        if (cfg_ch.index == CFG_COLS) cols_cfg_r <= cfg_ch.data;
      end
      if (in_acc) maxw_r <= in_ch.last ? '0 : wmax_in;
      if (cmd.op == OP_PHASE) sp_r <= '0;
      else if (cmd.op == OP_POP && sp_r != '0) sp_r <= sp_r - SPW'(1);
      else if (push_ok) sp_r <= sp_r + SPW'(1);
      if (cmd.op == OP_OUT && out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // solver datapath
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_IDLE: begin
        if (in_acc && in_ch.last) begin
          w_r  <= wmax_in;
          m_r  <= m_in;
          n_r  <= n_in;
          ri_r <= '0;
          cj_r <= '0;
        end
      end
      OP_WEV: begin
        if (rdata_r > w_r) w_r <= rdata_r;
        if (col_end) begin
          cj_r <= '0;
          ri_r <= ri_r + RIW'(1);
        end else begin
          cj_r <= cj_r + CIW'(1);
        end
      end
      OP_INIT: begin
        for (int i = 0; i < MAX_ROWS; i++) begin
          lm_v_r[i] <= 1'b0;
          lp_r[i]   <= PW'(w_r);
        end
        for (int j = 0; j < MAX_COLS; j++) begin
          rm_v_r[j] <= 1'b0;
          rp_r[j]   <= '0;
        end
        ri_r <= '0;
      end
      OP_PHASE: begin
        for (int i = 0; i < MAX_ROWS; i++) lreach_r[i] <= 1'b0;
        for (int j = 0; j < MAX_COLS; j++) begin
          rreach_r[j] <= 1'b0;
          slack_r[j]  <= SLACK_INF;
        end
        ri_r <= '0;
      end
      OP_PUSHL: begin
        if (!lm_v_r[ri_r]) lreach_r[ri_r] <= 1'b1;
        ri_r <= ri_r + RIW'(1);
      end
      OP_POP: begin
        ri_r <= '0;
        cj_r <= '0;
        d1_r <= SLACK_INF;
        d2_r <= SLACK_INF;
      end
      OP_POPD: begin
        if (!pop_side) begin
          a_r  <= RIW'(pop_idx);
          cj_r <= CIW'(n_r - CCW'(1));
        end else begin
          b_r <= pb;
          if (rm_v_r[pb] && !lreach_r[popd_a]) lreach_r[popd_a] <= 1'b1;
        end
      end
      OP_ROW_EV: begin
        if (upd_row) begin
          slack_r[cj_r] <= z_row;
          par_r[cj_r]   <= a_r;
          if (z_row == '0) rreach_r[cj_r] <= 1'b1;
        end
        cj_r <= cj_r - CIW'(1);
      end
      OP_FLIP: begin
        rm_v_r[b_r]    <= 1'b1;
        rm_a_r[b_r]    <= flip_a;
        lm_v_r[flip_a] <= 1'b1;
        lm_c_r[flip_a] <= b_r;
        if (lm_v_r[flip_a]) b_r <= lm_c_r[flip_a];
      end
      OP_D1: begin
        if (!lm_v_r[ri_r]) d1_r <= SW'(lp_r[ri_r]);
        ri_r <= ri_r + RIW'(1);
      end
      OP_D2: begin
        if (!rreach_r[cj_r] && slack_r[cj_r] < d2_r) d2_r <= slack_r[cj_r];
        cj_r <= cj_r + CIW'(1);
      end
      OP_UPD: begin
        if (!stop) begin
          for (int i = 0; i < MAX_ROWS; i++)
            if (lreach_r[i]) lp_r[i] <= lp_r[i] - PW'(d2_r);
          for (int j = 0; j < MAX_COLS; j++)
            if (rreach_r[j]) rp_r[j] <= rp_r[j] + PW'(d2_r);
        end
        ri_r <= '0;
        cj_r <= '0;
      end
      OP_SLK: begin
        if (slk_upd) begin
          slack_r[cj_r] <= s_new;
          if (s_new == '0) rreach_r[cj_r] <= 1'b1;
        end
        cj_r <= cj_r + CIW'(1);
      end
      OP_OUT: begin
        if (out_load) begin
          row_res_r   <= ROW_BITS'(ri_r);
          col_res_r   <= lm_v_r[ri_r] ? COL_BITS'(lm_c_r[ri_r]) : '0;
          matched_r   <= lm_v_r[ri_r];
          last_pair_r <= row_end;
          ri_r        <= ri_r + RIW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_res   = row_res_r;
  assign out_ch.col_res   = col_res_r;
  assign out_ch.matched   = matched_r;
  assign out_ch.last_pair = last_pair_r;

endmodule

// ===== src/max_weight_bipartite_matching.sv =====
// Maximum-weight bipartite matching (Hungarian method). Weight entries are
// taken one per cycle while the block is idle. The entry flagged last starts
// the solve, during which no entry is accepted: a scan of the rows-by-columns
// area in use reads, then evaluates, each entry via the weight memory's single
// read port; each row search reads and evaluates each column, each flip walks
// the augmenting path edge by edge, and each potential adjustment scans rows
// once and columns twice, so total solve time depends on the data. One result
// per row in use then leaves at up to one per cycle, and the next matrix may
// start loading while the final result still waits.
module max_weight_bipartite_matching import mwbm_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input logic        clk,
  input logic        rst_n,
  mwbm_in_if.sink    in_ch,
  mwbm_out_if.source out_ch,
  mwbm_cfg_if.sink   cfg_ch
);

  mwbm_cmd_t  cmd;
  mwbm_stat_t stat;

  mwbm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  mwbm_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

endmodule
